@@ rtl/core/tempo_synced_feedback_delay_defines.svh @@
// ----------------------------------------------------------------------------
// tempo synced feedback delay: assertion macros
// shared concurrent assertion forms, clocked on the rising edge and
// disabled while the active-low reset is asserted
// ----------------------------------------------------------------------------
`ifndef TEMPO_SYNCED_FEEDBACK_DELAY_DEFINES_SVH
`define TEMPO_SYNCED_FEEDBACK_DELAY_DEFINES_SVH

// same-cycle implication
`define TSFD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tsfd assertion failed");

// next-cycle implication
`define TSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tsfd assertion failed");

`endif

@@ rtl/core/tsfd_pkg.sv @@
// ----------------------------------------------------------------------------
// tsfd_pkg
// sizes, register map, lag state codes and the beat fraction table of the
// tempo synced feedback delay
// ----------------------------------------------------------------------------
package tsfd_pkg;

    // delay memory and sample format
    localparam int DEPTH       = 65536;
    localparam int ADDR_BITS   = $clog2(DEPTH);
    localparam int SAMPLE_BITS = 24;
    localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;

    // register fields
    localparam int GAIN_BITS  = 5;
    localparam int GAIN_MAX   = 20;
    localparam int TIME_BITS  = 3;
    localparam int TEMPO_BITS = 9;
    localparam int RATE_BITS  = 17;

    // apb register map
    localparam int NUM_REGS      = 8;
    localparam int CFG_ADDR_BITS = $clog2(NUM_REGS) + 2;
    localparam int CFG_DATA_BITS = 32;

    // lag computation
    localparam int SECONDS_PER_MINUTE = 60;
    localparam int BEAT_BITS    = RATE_BITS + $clog2(SECONDS_PER_MINUTE);
    localparam int FRAC_BITS    = 17;
    localparam int FRAC_SHIFT   = 16;
    localparam int LPROD_BITS   = BEAT_BITS + FRAC_BITS;
    localparam int LAG_RAW_BITS = LPROD_BITS - FRAC_SHIFT;
    localparam int DIV_CNT_BITS = $clog2(BEAT_BITS);

    // mix arithmetic: divide by twenty as a shift by two then times 1/5
    localparam int SUM_BITS    = SAMPLE_BITS + 6;
    localparam int MAG_BITS    = SUM_BITS - 1;
    localparam int QIN_BITS    = MAG_BITS - 2;
    localparam int DIV_ODD     = GAIN_MAX / 4;
    localparam int RECIP_SHIFT = QIN_BITS + 3;
    localparam int RECIP_BITS  = QIN_BITS + 1;
    localparam int PROD_BITS   = QIN_BITS + RECIP_BITS;
    localparam int QUO_BITS    = PROD_BITS - RECIP_SHIFT;
    localparam logic [RECIP_BITS-1:0] RECIP =
        RECIP_BITS'((64'd1 << RECIP_SHIFT) / 64'(DIV_ODD));

    // sample path depth from accept to the output register
    localparam int PIPE_STAGES = 4;

    typedef enum logic [2:0] {
        REG_ENABLE,
        REG_TIME,
        REG_LEVEL,
        REG_FEEDBACK,
        REG_DRY,
        REG_WET,
        REG_TEMPO,
        REG_RATE
    } reg_idx_t;

    typedef enum logic [2:0] {
        LAG_LOAD,
        LAG_DIV,
        LAG_MUL,
        LAG_CAP,
        LAG_IDLE
    } lag_state_t;

    // beat fraction in q16, codes above one beat read as one beat
    function automatic logic [FRAC_BITS-1:0] frac_q16(input logic [TIME_BITS-1:0] sel);
        logic [FRAC_BITS-1:0] f;
        case (sel)
            3'd0:    f = FRAC_BITS'(8192);
            3'd1:    f = FRAC_BITS'(10918);
            3'd2:    f = FRAC_BITS'(16384);
            3'd3:    f = FRAC_BITS'(21843);
            3'd4:    f = FRAC_BITS'(32768);
            default: f = FRAC_BITS'(65536);
        endcase
        return f;
    endfunction

endpackage

@@ rtl/core/tsfd_ram.sv @@
// ----------------------------------------------------------------------------
// tsfd_ram
// generic single write port, single read port memory with registered read
// ----------------------------------------------------------------------------
module tsfd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/tempo_synced_feedback_delay.sv @@
// ----------------------------------------------------------------------------
// tempo_synced_feedback_delay
// tempo synced echo: a delay memory read at the record pointer minus a lag
// taken from tempo, sample rate and beat fraction, with feedback and a
// dry/wet mix
// ----------------------------------------------------------------------------
// Takes one signed sample per clock while the output is not stalled and no
// hold-off below applies, and returns one sample per input; the delay memory
// does one read (at accept) and one write (as the sample leaves stage 3) per
// sample. After reset the input is held off while the memory is swept to
// zero. After every register write the input is held off while the lag is
// recomputed by a bit-serial divider (one load, 23 quotient bits, one
// multiply, one clamp). When the lag is one
// to three samples a new sample waits until the write of the earlier sample
// it reads has landed. Registers are to be written only while no sample is in
// flight; the block itself does not enforce this. With enable low samples
// pass through unchanged and the memory and record pointer are left alone.
// ----------------------------------------------------------------------------
module tempo_synced_feedback_delay (
    input  logic                                aclk,
    input  logic                                aresetn,
    // sample_in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tsfd_pkg::TDATA_BITS-1:0]     s_tdata,    // [23:0] sample_in
    // sample_out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tsfd_pkg::TDATA_BITS-1:0]     m_tdata,    // [23:0] sample_out
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tsfd_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [tsfd_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [tsfd_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                pready
);

    import tsfd_pkg::*;

    localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    function automatic logic signed [GAIN_BITS:0] gain_clamp(input logic [GAIN_BITS-1:0] s);
        logic [GAIN_BITS-1:0] g;
        g = (s > GAIN_BITS'(GAIN_MAX)) ? GAIN_BITS'(GAIN_MAX) : s;
        return {1'b0, g};
    endfunction

    // finish floor(a/5) from the reciprocal product, restore the sign, saturate
    function automatic logic [SAMPLE_BITS-1:0] div20_sat(
        input logic                 neg,
        input logic [QIN_BITS-1:0]  a,
        input logic [PROD_BITS-1:0] p
    );
        logic [QUO_BITS-1:0]    q0;
        logic [QUO_BITS-1:0]    q;
        logic [QUO_BITS-1:0]    nq;
        logic [QIN_BITS-1:0]    r;
        logic [SAMPLE_BITS-1:0] res;
        q0 = p[PROD_BITS-1:RECIP_SHIFT];
        r  = a - (QIN_BITS'({q0, 2'b00}) + QIN_BITS'(q0));
        q  = (r >= QIN_BITS'(DIV_ODD)) ? q0 + QUO_BITS'(1) : q0;
        nq = -q;
        if (!neg) begin
            res = (q > QUO_BITS'(SAT_MAX)) ? SAT_MAX : q[SAMPLE_BITS-1:0];
        end else begin
            res = (q > QUO_BITS'(SAT_MIN)) ? SAT_MIN : nq[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    logic                  enable_reg;
    logic [TIME_BITS-1:0]  time_reg;
    logic [GAIN_BITS-1:0]  level_reg;
    logic [GAIN_BITS-1:0]  feedback_reg;
    logic [GAIN_BITS-1:0]  dry_reg;
    logic [GAIN_BITS-1:0]  wet_reg;
    logic [TEMPO_BITS-1:0] tempo_reg;
    logic [RATE_BITS-1:0]  rate_reg;
    logic                  cfg_wr;
    reg_idx_t              cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= 1'b0;
            time_reg     <= TIME_BITS'(2);
            level_reg    <= GAIN_BITS'(10);
            feedback_reg <= GAIN_BITS'(5);
            dry_reg      <= GAIN_BITS'(20);
            wet_reg      <= GAIN_BITS'(10);
            tempo_reg    <= TEMPO_BITS'(120);
            rate_reg     <= RATE_BITS'(48000);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ENABLE:   enable_reg   <= pwdata[0];
                REG_TIME:     time_reg     <= pwdata[TIME_BITS-1:0];
                REG_LEVEL:    level_reg    <= pwdata[GAIN_BITS-1:0];
                REG_FEEDBACK: feedback_reg <= pwdata[GAIN_BITS-1:0];
                REG_DRY:      dry_reg      <= pwdata[GAIN_BITS-1:0];
                REG_WET:      wet_reg      <= pwdata[GAIN_BITS-1:0];
                REG_TEMPO:    tempo_reg    <= pwdata[TEMPO_BITS-1:0];
                REG_RATE:     rate_reg     <= pwdata[RATE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ENABLE:   prdata = CFG_DATA_BITS'(enable_reg);
            REG_TIME:     prdata = CFG_DATA_BITS'(time_reg);
            REG_LEVEL:    prdata = CFG_DATA_BITS'(level_reg);
            REG_FEEDBACK: prdata = CFG_DATA_BITS'(feedback_reg);
            REG_DRY:      prdata = CFG_DATA_BITS'(dry_reg);
            REG_WET:      prdata = CFG_DATA_BITS'(wet_reg);
            REG_TEMPO:    prdata = CFG_DATA_BITS'(tempo_reg);
            REG_RATE:     prdata = CFG_DATA_BITS'(rate_reg);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // lag unit: bit-serial 60*rate/tempo, then times the beat fraction
    // ------------------------------------------------------------------
    lag_state_t              lag_state_reg, lag_state_next;
    logic                    lag_idle;
    logic [BEAT_BITS-1:0]    dq_reg;
    logic [TEMPO_BITS-1:0]   rem_reg;
    logic [TEMPO_BITS-1:0]   dvsr_reg;
    logic [DIV_CNT_BITS-1:0] dcnt_reg;
    logic [LPROD_BITS-1:0]   lprod_reg;
    logic [ADDR_BITS-1:0]    lag_reg;
    logic [TEMPO_BITS:0]     trial;
    logic                    qbit;
    logic [TEMPO_BITS-1:0]   rem_next;
    logic [LAG_RAW_BITS-1:0] lag_raw;
    logic [ADDR_BITS-1:0]    lag_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lag_state_reg <= LAG_LOAD;
        end else begin
            lag_state_reg <= lag_state_next;
        end
    end

    always_comb begin
        lag_state_next = lag_state_reg;
        lag_idle       = 1'b0;
        case (lag_state_reg)
            LAG_LOAD: lag_state_next = LAG_DIV;
            LAG_DIV: begin
                if (dcnt_reg == DIV_CNT_BITS'(BEAT_BITS - 1)) begin
                    lag_state_next = LAG_MUL;
                end
            end
            LAG_MUL:  lag_state_next = LAG_CAP;
            LAG_CAP:  lag_state_next = LAG_IDLE;
            LAG_IDLE: lag_idle = 1'b1;
            default:  lag_state_next = LAG_LOAD;
        endcase
        // any register write restarts the computation
        if (cfg_wr) begin
            lag_state_next = LAG_LOAD;
            lag_idle       = 1'b0;
        end
    end

    assign trial    = {rem_reg, dq_reg[BEAT_BITS-1]};
    assign qbit     = (trial >= {1'b0, dvsr_reg});
    assign rem_next = qbit ? TEMPO_BITS'(trial - {1'b0, dvsr_reg}) : trial[TEMPO_BITS-1:0];
    assign lag_raw  = lprod_reg[LPROD_BITS-1:FRAC_SHIFT];
    // tempo zero or a lag past the memory both pin to the oldest entry
    assign lag_next = ((dvsr_reg == '0) || (lag_raw > LAG_RAW_BITS'(DEPTH - 1))) ?
                      ADDR_BITS'(DEPTH - 1) : lag_raw[ADDR_BITS-1:0];

    always_ff @(posedge aclk) begin
        case (lag_state_reg)
            LAG_LOAD: begin
                dq_reg   <= BEAT_BITS'(rate_reg) * BEAT_BITS'(SECONDS_PER_MINUTE);
                rem_reg  <= '0;
                dvsr_reg <= tempo_reg;
                dcnt_reg <= '0;
            end
            LAG_DIV: begin
                dq_reg   <= {dq_reg[BEAT_BITS-2:0], qbit};
                rem_reg  <= rem_next;
                dcnt_reg <= dcnt_reg + DIV_CNT_BITS'(1);
            end
            LAG_MUL: lprod_reg <= LPROD_BITS'(dq_reg) * LPROD_BITS'(frac_q16(time_reg));
            LAG_CAP: lag_reg   <= lag_next;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // memory clear sweep after reset
    // ------------------------------------------------------------------
    logic                 clr_busy_reg;
    logic [ADDR_BITS-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + ADDR_BITS'(1);
            if (clr_addr_reg == ADDR_BITS'(DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // sample pipeline
    // stage 1: memory read data, stage 2: gain sums,
    // stage 3: reciprocal products, stage 4: output register
    // ------------------------------------------------------------------
    logic adv1, adv2, adv3, adv4;
    logic s_accept;
    logic hazard;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic act1_reg, act2_reg, act3_reg;
    logic signed [SAMPLE_BITS-1:0] x1_reg, x2_reg, x3_reg;
    logic [ADDR_BITS-1:0] wa1_reg, wa2_reg, wa3_reg;
    logic [ADDR_BITS-1:0] rp_reg;
    logic [ADDR_BITS:0]   rd_wrap;
    logic [ADDR_BITS-1:0] rd_addr;

    logic [SAMPLE_BITS-1:0]        rd_data;
    logic signed [SAMPLE_BITS-1:0] dly;
    logic signed [GAIN_BITS:0]     lvl_g, fb_g, dry_g, wet_g;
    logic signed [SUM_BITS-1:0]    wsum2_next, ysum2_next;
    logic signed [SUM_BITS-1:0]    wsum2_reg, ysum2_reg;

    logic signed [SUM_BITS-1:0] wabs, yabs;
    logic [QIN_BITS-1:0]        wa_next, ya_next;
    logic [QIN_BITS-1:0]        wa3q_reg, ya3q_reg;
    logic                       wneg3_reg, yneg3_reg;
    logic [PROD_BITS-1:0]       wprod3_reg, yprod3_reg;

    logic [SAMPLE_BITS-1:0] wr_res, y_res;
    logic [SAMPLE_BITS-1:0] out4_reg;

    logic                   ram_we;
    logic [ADDR_BITS-1:0]   ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;

    assign adv4 = !v4_reg || m_tready;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    // read address: record pointer minus lag, wrapped into the memory
    assign rd_wrap = ({1'b0, rp_reg} >= {1'b0, lag_reg}) ?
                     ({1'b0, rp_reg} - {1'b0, lag_reg}) :
                     ({1'b0, rp_reg} + (ADDR_BITS+1)'(DEPTH) - {1'b0, lag_reg});
    assign rd_addr = rd_wrap[ADDR_BITS-1:0];

    // hold off while an older sample still has to write the entry we read
    assign hazard = enable_reg &&
                    ((v1_reg && act1_reg && (wa1_reg == rd_addr)) ||
                     (v2_reg && act2_reg && (wa2_reg == rd_addr)) ||
                     (v3_reg && act3_reg && (wa3_reg == rd_addr)));

    assign s_tready = adv1 && !clr_busy_reg && lag_idle && !hazard;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rp_reg <= '0;
        end else if (s_accept && enable_reg) begin
            rp_reg <= (rp_reg == ADDR_BITS'(DEPTH - 1)) ? '0 : rp_reg + ADDR_BITS'(1);
        end
    end

    tsfd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_delay_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_accept && enable_reg),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign ram_we    = clr_busy_reg || (v3_reg && adv4 && act3_reg);
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : wa3_reg;
    assign ram_wdata = clr_busy_reg ? '0 : wr_res;

    // stage 1 -> 2
    assign dly   = rd_data;
    assign lvl_g = gain_clamp(level_reg);
    assign fb_g  = gain_clamp(feedback_reg);
    assign dry_g = gain_clamp(dry_reg);
    assign wet_g = gain_clamp(wet_reg);

    assign wsum2_next = SUM_BITS'(x1_reg) * SUM_BITS'(lvl_g)
                      + SUM_BITS'(dly) * SUM_BITS'(fb_g);
    assign ysum2_next = (SUM_BITS'(x1_reg) + SUM_BITS'(dly)) * SUM_BITS'(wet_g)
                      + SUM_BITS'(x1_reg) * SUM_BITS'(dry_g);

    // stage 2 -> 3: magnitude, drop the factor of four, times 1/5
    assign wabs    = wsum2_reg[SUM_BITS-1] ? -wsum2_reg : wsum2_reg;
    assign yabs    = ysum2_reg[SUM_BITS-1] ? -ysum2_reg : ysum2_reg;
    assign wa_next = wabs[MAG_BITS-1:2];
    assign ya_next = yabs[MAG_BITS-1:2];

    // stage 3 -> 4
    assign wr_res = div20_sat(wneg3_reg, wa3q_reg, wprod3_reg);
    assign y_res  = div20_sat(yneg3_reg, ya3q_reg, yprod3_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= s_accept;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
            if (adv3) begin
                v3_reg <= v2_reg;
            end
            if (adv4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            x1_reg   <= s_tdata[SAMPLE_BITS-1:0];
            act1_reg <= enable_reg;
            wa1_reg  <= rp_reg;
        end
        if (adv2 && v1_reg) begin
            x2_reg    <= x1_reg;
            act2_reg  <= act1_reg;
            wa2_reg   <= wa1_reg;
            wsum2_reg <= wsum2_next;
            ysum2_reg <= ysum2_next;
        end
        if (adv3 && v2_reg) begin
            x3_reg     <= x2_reg;
            act3_reg   <= act2_reg;
            wa3_reg    <= wa2_reg;
            wneg3_reg  <= wsum2_reg[SUM_BITS-1];
            yneg3_reg  <= ysum2_reg[SUM_BITS-1];
            wa3q_reg   <= wa_next;
            ya3q_reg   <= ya_next;
            wprod3_reg <= PROD_BITS'(wa_next) * PROD_BITS'(RECIP);
            yprod3_reg <= PROD_BITS'(ya_next) * PROD_BITS'(RECIP);
        end
        if (adv4 && v3_reg) begin
            out4_reg <= act3_reg ? y_res : x3_reg;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = TDATA_BITS'(out4_reg);

endmodule

@@ rtl/core/tsfd_checker.sv @@
// ----------------------------------------------------------------------------
// tsfd_checker
// port-level checks of the tempo synced feedback delay: output hold,
// sample accounting and input hold-off after reset and register writes
// ----------------------------------------------------------------------------
`include "tempo_synced_feedback_delay_defines.svh"

module tsfd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tsfd_pkg::TDATA_BITS-1:0] m_tdata,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic                            pready
);

    import tsfd_pkg::*;

    logic       in_acc, out_acc;
    logic [2:0] cnt_reg, cnt_next;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // samples accepted but not yet delivered
    always_comb begin
        cnt_next = cnt_reg + 3'(in_acc) - 3'(out_acc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    `TSFD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `TSFD_ASSERT_IMPLY(a_no_extra, aclk, aresetn, out_acc, cnt_reg != 3'd0)
    `TSFD_ASSERT_IMPLY(a_occupancy, aclk, aresetn, 1'b1, cnt_reg <= 3'(PIPE_STAGES))
    `TSFD_ASSERT_NEXT(a_cfg_holdoff, aclk, aresetn, psel && penable && pwrite && pready, !s_tready)
    `TSFD_ASSERT_IMPLY(a_reset_holdoff, aclk, aresetn, $past(!aresetn), !s_tready)

endmodule

bind tempo_synced_feedback_delay tsfd_checker u_tsfd_checker (.*);

@@ tb/sv/tempo_synced_feedback_delay_tb.sv @@
// ----------------------------------------------------------------------------
// tempo_synced_feedback_delay_tb
// Sends audio samples through the echo and compares every output sample
// against a bit-exact software echo kept in a scoreboard. That echo has its
// own delay line, record position and lag. Register settings change between
// phases: short lags that feed back quickly, realistic tempos, and
// out-of-range codes.
// ----------------------------------------------------------------------------
module tempo_synced_feedback_delay_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsfd_pkg::*;

    localparam int     DRAIN_CYCLES  = PIPE_STAGES + 4;
    localparam int     RANDOM_ITEMS  = 950;
    localparam int     REPORT_LIMIT  = 40;
    localparam longint SAT_HI        = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_LO        = -SAT_HI - 1;
    localparam logic [SAMPLE_BITS-1:0] POS_FULL = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] NEG_FULL = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // echo scoreboard: software echo plus the queue of output samples it predicts
    class echo_scoreboard;
        logic signed [SAMPLE_BITS-1:0] line_mem [DEPTH];
        int unsigned wr_ptr;
        int unsigned lag;
        bit          enabled;
        int unsigned beat_sel, send_step, fb_step, dry_step, wet_step, tempo, rate;
        logic [SAMPLE_BITS-1:0] expected_q [$];
        int          errors;
        int          samples_in;
        int          results;

        function new();
            foreach (line_mem[i]) line_mem[i] = '0;
            wr_ptr     = 0;
            enabled    = 1'b0;
            beat_sel   = 2;
            send_step  = 10;
            fb_step    = 5;
            dry_step   = 20;
            wet_step   = 10;
            tempo      = 120;
            rate       = 48000;
            errors     = 0;
            samples_in = 0;
            results    = 0;
            update_lag();
        endfunction

        function longint unsigned beat_q16(int unsigned sel);
            case (sel)
                0:       return 8192;
                1:       return 10918;
                2:       return 16384;
                3:       return 21843;
                4:       return 32768;
                default: return 65536;
            endcase
        endfunction

        function longint twentieths(int unsigned s);
            return (s > GAIN_MAX) ? longint'(GAIN_MAX) : longint'(s);
        endfunction

        function logic [SAMPLE_BITS-1:0] clip(longint v);
            if (v > SAT_HI) return POS_FULL;
            if (v < SAT_LO) return NEG_FULL;
            return v[SAMPLE_BITS-1:0];
        endfunction

        function void update_lag();
            longint unsigned beat;
            longint unsigned span;
            if (tempo == 0) begin
                span = DEPTH - 1;
            end else begin
                beat = (64'(SECONDS_PER_MINUTE) * rate) / tempo;
                span = (beat * beat_q16(beat_sel)) >> FRAC_SHIFT;
            end
            if (span > DEPTH - 1) span = DEPTH - 1;
            lag = int'(span);
        endfunction

        function void write_reg(reg_idx_t idx, int unsigned v);
            case (idx)
                REG_ENABLE:   enabled   = v[0];
                REG_TIME:     beat_sel  = v & 32'h7;
                REG_LEVEL:    send_step = v & 32'h1f;
                REG_FEEDBACK: fb_step   = v & 32'h1f;
                REG_DRY:      dry_step  = v & 32'h1f;
                REG_WET:      wet_step  = v & 32'h1f;
                REG_TEMPO:    tempo     = v & 32'h1ff;
                REG_RATE:     rate      = v & 32'h1ffff;
                default: ;
            endcase
            update_lag();
        endfunction

        // one accepted request: tap the line, write the feedback, predict the mix
        function void note_sample(logic [SAMPLE_BITS-1:0] raw);
            longint      x;
            longint      echo;
            longint      fed;
            longint      mix;
            int unsigned rd;
            samples_in++;
            if (!enabled) begin
                expected_q.push_back(raw);
                return;
            end
            x    = longint'($signed(raw));
            rd   = (wr_ptr + DEPTH - lag) % DEPTH;
            echo = line_mem[rd];
            fed  = (x * twentieths(send_step) + echo * twentieths(fb_step)) / 20;
            mix  = ((x + echo) * twentieths(wet_step) + x * twentieths(dry_step)) / 20;
            line_mem[wr_ptr] = clip(fed);
            wr_ptr = (wr_ptr + 1) % DEPTH;
            expected_q.push_back(clip(mix));
        endfunction

        task report_mismatch(string what);
            // keep the log short when the design is badly off
            if (errors < REPORT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic [SAMPLE_BITS-1:0] got);
            logic [SAMPLE_BITS-1:0] want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("sample_out %h with no request outstanding", got));
                return;
            end
            want = expected_q.pop_front();
            results++;
            if (got !== want)
                report_mismatch($sformatf("sample_out %0d: got %h, want %h",
                                          results, got, want));
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                      aclk     = 1'b0;
    logic                      aresetn  = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [TDATA_BITS-1:0]     s_tdata  = '0;    // [23:0] sample_in
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [TDATA_BITS-1:0]     m_tdata;          // [23:0] sample_out
    logic                      psel     = 1'b0;
    logic                      penable  = 1'b0;
    logic                      pwrite   = 1'b0;
    logic [CFG_ADDR_BITS-1:0]  paddr    = '0;
    logic [CFG_DATA_BITS-1:0]  pwdata   = '0;
    logic [CFG_DATA_BITS-1:0]  prdata;
    logic                      pready;

    echo_scoreboard sb;
    int             reg_writes = 0;
    int             settings_applied = 0;
    int unsigned    rx_mode = 0;
    int unsigned    rx_left = 0;

    tempo_synced_feedback_delay u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // receiver stalls: free running, mostly ready, mostly stalled, or periodic
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(16, 96);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (rx_left[3:0] >= 4'd10);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata[SAMPLE_BITS-1:0]);
    end

    task automatic push_sample(input logic [SAMPLE_BITS-1:0] x);
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_BITS'(x);
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(x);
    endtask

    // let every request come out, then allow the pipeline to run empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input int unsigned v);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, v);
        reg_writes++;
    endtask

    task automatic apply_settings(input int unsigned en, input int unsigned sel,
                                  input int unsigned lvl, input int unsigned fb,
                                  input int unsigned dry, input int unsigned wet,
                                  input int unsigned bpm, input int unsigned hz);
        apb_write(REG_ENABLE, en);
        apb_write(REG_TIME, sel);
        apb_write(REG_LEVEL, lvl);
        apb_write(REG_FEEDBACK, fb);
        apb_write(REG_DRY, dry);
        apb_write(REG_WET, wet);
        apb_write(REG_TEMPO, bpm);
        apb_write(REG_RATE, hz);
        settings_applied++;
    endtask

    function automatic int unsigned random_step();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 20);
    endfunction

    task automatic random_settings();
        int unsigned mode;
        int unsigned bpm;
        int unsigned hz;
        mode = $urandom_range(0, 9);
        // short lags mostly, so echoes and feedback come back within a phase
        if (mode < 6) begin
            bpm = $urandom_range(20, 300);
            hz  = $urandom_range(0, 400);
        end else if (mode < 8) begin
            bpm = $urandom_range(20, 300);
            hz  = $urandom_range(8000, 96000);
        end else begin
            bpm = $urandom_range(0, 511);
            hz  = $urandom_range(0, 131071);
        end
        apply_settings(($urandom_range(0, 7) != 0), $urandom_range(0, 7), random_step(),
                       random_step(), random_step(), random_step(), bpm, hz);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return POS_FULL;
                    1:       return NEG_FULL;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            1, 2:    return SAMPLE_BITS'($urandom_range(0, 511) - 256);
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    task automatic run_random(input int n);
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 24);
        for (int i = 0; i < n; i++) begin
            push_sample(random_sample());
            burst_left--;
            if (burst_left == 0 && i != n - 1) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    endtask

    initial begin
        int sent;
        int n;
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // bypass at reset settings, full scale and bit patterns
        push_sample(POS_FULL);
        push_sample(NEG_FULL);
        push_sample('0);
        push_sample('1);
        push_sample(24'h555555);
        push_sample(24'haaaaaa);
        settle();

        // enable alone: reset gains give 1.5x and saturate at full scale
        apb_write(REG_ENABLE, 1);
        push_sample(POS_FULL);
        push_sample(NEG_FULL);
        settle();

        // two-sample lag, all gains full: feedback piles up and saturates
        apply_settings(1, 5, 20, 20, 20, 20, 60, 2);
        push_sample(POS_FULL);
        push_sample(POS_FULL);
        push_sample(POS_FULL);
        push_sample(NEG_FULL);
        push_sample(NEG_FULL);
        push_sample(24'h000001);
        push_sample(24'h400000);
        settle();

        // one-sample lag reads the write of the previous request
        apply_settings(1, 5, 20, 19, 20, 20, 60, 1);
        push_sample(24'h3fffff);
        push_sample(24'hc00001);
        push_sample(24'h123456);
        settle();

        // codes past the top: time select, gains above twenty, tempo zero
        apply_settings(1, 7, 31, 31, 31, 31, 0, 48000);
        push_sample(NEG_FULL);
        push_sample(POS_FULL);
        settle();

        // zero rate gives zero lag; zero dry gain
        apply_settings(1, 3, 20, 10, 0, 20, 300, 0);
        push_sample(24'h123456);
        push_sample(24'h876543);
        settle();

        // lag far beyond the line is capped
        apply_settings(1, 0, 7, 13, 3, 17, 1, 131071);
        push_sample(24'h000002);
        settle();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            random_settings();
            n = $urandom_range(40, 120);
            if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
            run_random(n);
            sent += n;
            settle();
        end

        $display("sent %0d samples and compared %0d outputs", sb.samples_in, sb.results);
        $display("%0d register settings applied with %0d register writes",
                 settings_applied, reg_writes);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** tempo_synced_feedback_delay: PASSED **");
        end else begin
            $display("** tempo_synced_feedback_delay: FAILED **");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("timeout waiting on the design");
        $display("** tempo_synced_feedback_delay: FAILED **");
        $finish;
    end

endmodule
